// ----- rtl/sorted_timer_queue_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted timer queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_CORE_MACROS_SVH
`define SORTED_TIMER_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/stq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Types, sizes and codes shared by the sorted timer queue modules.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int CAPACITY    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

	localparam int ACTION_W = 2;
	localparam int KEY_W    = 16;
	localparam int DELAY_W  = 16;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 3;

	localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CANCEL  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_SCHEDULED   = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_RESCHEDULED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_CANCELLED   = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_FULL        = 3'd4;
	localparam logic [STATUS_W-1:0] STATUS_EXPIRED     = 3'd5;
	localparam logic [STATUS_W-1:0] STATUS_NONE_DUE    = 3'd6;

	typedef logic [1:0] cell_sel_t;

	localparam cell_sel_t CELL_KEEP      = 2'd0;
	localparam cell_sel_t CELL_FROM_PREV = 2'd1;
	localparam cell_sel_t CELL_FROM_NEXT = 2'd2;
	localparam cell_sel_t CELL_LOAD      = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] deadline;
	} entry_t;

	typedef struct packed {
		cell_sel_t         sel;
		logic [KEY_W-1:0]  search_key;
		logic [TIME_W-1:0] ref_time;
	} cell_ctrl_t;

endpackage

// ----- rtl/stq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted queue: holds a key and deadline, compares them
// against the broadcast search key and reference time, and loads from either
// neighbour or from the broadcast new entry.
// ----------------------------------------------------------------------------
module stq_cell
	import stq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     prev_entry,
	input  entry_t     next_entry,
	input  entry_t     new_entry,
	output entry_t     entry,
	output logic       match,
	output logic       later
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.sel)
			CELL_FROM_PREV: entry_q <= prev_entry;
			CELL_FROM_NEXT: entry_q <= next_entry;
			CELL_LOAD:      entry_q <= new_entry;
			default:        entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;
	assign match = (entry_q.key == ctrl.search_key);
	assign later = (entry_q.deadline > ctrl.ref_time);

endmodule

// ----- rtl/sorted_timer_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_core
// Deadline-ordered timer queue built as a row of cells that shift left on a
// removal and right on a sorted insert.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// command   in         start high while busy low    action, timer_key,
//                                                   delay_seconds, current_time
// result    out        result_valid, one cycle      status, result_key,
//                                                   result_time, last_result
//
// A request passes through the accepting edge, a search state in which every
// cell compares its key and a matching timer is taken out by a left shift,
// and an insert state in which every cell compares its deadline and the new
// timer is dropped in by a right shift. A request for a new key against a
// full queue ends after the search. A cancel ends after the search, which
// removes a matching timer. A tick is accepted and then shows one expired
// timer per cycle, or a single none-due beat when nothing is due; the head
// cell is read and the row shifts left once per expired beat. Each result
// beat is registered and appears in the cycle after the one that produced
// it; busy falls in the cycle that shows the final beat of an item, so the
// next command may be taken then. Unused action code 3 is accepted and dropped.
// Reset clears the fill count, the state and the result strobe; the cell
// contents are not reset and are never read beyond the fill count.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core
	import stq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ACTION_W-1:0] action,
	input  logic [KEY_W-1:0]    timer_key,
	input  logic [DELAY_W-1:0]  delay_seconds,
	input  logic [TIME_W-1:0]   current_time,
	output logic                result_valid,
	output logic [STATUS_W-1:0] status,
	output logic [KEY_W-1:0]    result_key,
	output logic [TIME_W-1:0]   result_time,
	output logic                last_result
);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_FIND   = 2'd1;
	localparam logic [1:0] ST_INSERT = 2'd2;
	localparam logic [1:0] ST_EXPIRE = 2'd3;

	logic [1:0]          state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [NUM_W-1:0]    num_q, num_d;
	logic                found_q, found_d;

	// Latched command; these are payload and need no reset.
	logic [ACTION_W-1:0] action_q;
	logic [KEY_W-1:0]    key_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   deadline_q;

	// Result register.
	logic                valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0]    rkey_q;
	logic [TIME_W-1:0]   rtime_q;
	logic                last_q;

	logic                emit;
	logic [STATUS_W-1:0] emit_status;
	logic [KEY_W-1:0]    emit_key;
	logic [TIME_W-1:0]   emit_time;
	logic                emit_last;

	// The deadline of a request saturates at the top of the time range.
	logic [TIME_W:0]     sum;
	logic [TIME_W-1:0]   sat_deadline;

	// Cell row.
	cell_ctrl_t          ctrl   [CAPACITY];
	cell_sel_t           sel    [CAPACITY];
	entry_t              cell_entry [CAPACITY];
	entry_t              prev_arr   [CAPACITY];
	entry_t              next_arr   [CAPACITY];
	entry_t              new_entry;
	logic [CAPACITY-1:0] match_v;
	logic [CAPACITY-1:0] later_v;
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] from_hit;
	logic [CAPACITY-1:0] ins;
	logic [CAPACITY-1:0] ins_prev;
	logic                found;
	logic [TIME_W-1:0]   hit_deadline;
	logic                hit_later;
	logic                due_head;
	logic                due_second;
	logic                last_expiry;
	logic [TIME_W-1:0]   ref_time;

	assign sum          = {1'b0, current_time} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay_seconds};
	assign sat_deadline = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

	assign new_entry = '{key: key_q, deadline: deadline_q};

	// During insertion the cells compare against the new deadline; otherwise
	// against the time supplied with the command.
	assign ref_time = (state_q == ST_INSERT) ? deadline_q : now_q;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			if (g == 0) begin : g_first
				assign prev_arr[g] = new_entry;
			end else begin : g_mid
				assign prev_arr[g] = cell_entry[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign next_arr[g] = cell_entry[g];
			end else begin : g_rest
				assign next_arr[g] = cell_entry[g+1];
			end

			assign ctrl[g] = '{sel: sel[g], search_key: key_q, ref_time: ref_time};

			stq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl[g]),
				.prev_entry (prev_arr[g]),
				.next_entry (next_arr[g]),
				.new_entry  (new_entry),
				.entry      (cell_entry[g]),
				.match      (match_v[g]),
				.later      (later_v[g])
			);
		end
	endgenerate

	// Occupancy and per-cell flags. Keys are unique, so at most one cell hits.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occ[i] = (count_q > CNT_W'(i));
		end
		hit = match_v & occ;
		for (int i = 0; i < CAPACITY; i++) begin
			from_hit[i] = 1'b0;
			for (int j = 0; j < CAPACITY; j++) begin
				if (j <= i) begin
					from_hit[i] = from_hit[i] | hit[j];
				end
			end
		end
		found        = |hit;
		hit_deadline = '0;
		hit_later    = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i]) begin
				hit_deadline = hit_deadline | cell_entry[i].deadline;
				hit_later    = hit_later | later_v[i];
			end
		end
		// Cells that take the new entry or shift right: empty ones and those
		// with a strictly later deadline, which form a suffix of the row.
		ins      = ~occ | later_v;
		ins_prev = {ins[CAPACITY-2:0], 1'b0};
	end

	assign due_head    = occ[0] & ~later_v[0];
	assign due_second  = occ[1] & ~later_v[1];
	assign last_expiry = (num_q == NUM_W'(MAX_RESULTS - 1)) | ~due_second;

	// Sequencer.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		num_d       = num_q;
		found_d     = found_q;
		emit        = 1'b0;
		emit_status = STATUS_SCHEDULED;
		emit_key    = key_q;
		emit_time   = '0;
		emit_last   = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			sel[i] = CELL_KEEP;
		end

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					num_d   = '0;
					found_d = 1'b0;
					if (action == ACT_TICK) begin
						state_d = ST_EXPIRE;
					end else if (action == ACT_UNUSED) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_FIND;
					end
				end
			end

			ST_FIND: begin
				// A matching timer is removed by shifting everything after it
				// one place to the left.
				if (found) begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (from_hit[i]) begin
							sel[i] = CELL_FROM_NEXT;
						end
					end
					count_d = count_q - CNT_W'(1);
				end
				found_d = found;
				if (action_q == ACT_CANCEL) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					if (found) begin
						emit_status = STATUS_CANCELLED;
						emit_time   = hit_later ? (hit_deadline - now_q) : '0;
					end else begin
						emit_status = STATUS_NOT_FOUND;
						emit_time   = '0;
					end
					state_d = ST_IDLE;
				end else if (!found && (count_q == CNT_W'(CAPACITY))) begin
					emit        = 1'b1;
					emit_status = STATUS_FULL;
					emit_time   = '0;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_INSERT;
				end
			end

			ST_INSERT: begin
				// Cells after the insertion point shift right; the first of
				// them loads the new timer.
				for (int i = 0; i < CAPACITY; i++) begin
					if (ins_prev[i]) begin
						sel[i] = CELL_FROM_PREV;
					end else if (ins[i]) begin
						sel[i] = CELL_LOAD;
					end
				end
				count_d     = count_q + CNT_W'(1);
				emit        = 1'b1;
				emit_status = found_q ? STATUS_RESCHEDULED : STATUS_SCHEDULED;
				emit_time   = deadline_q;
				state_d     = ST_IDLE;
			end

			ST_EXPIRE: begin
				emit = 1'b1;
				if (due_head) begin
					for (int i = 0; i < CAPACITY; i++) begin
						sel[i] = CELL_FROM_NEXT;
					end
					count_d     = count_q - CNT_W'(1);
					num_d       = num_q + NUM_W'(1);
					emit_status = STATUS_EXPIRED;
					emit_key    = cell_entry[0].key;
					emit_time   = cell_entry[0].deadline;
					emit_last   = last_expiry;
					if (last_expiry) begin
						state_d = ST_IDLE;
					end
				end else begin
					// Only reached on the first cycle of a tick.
					emit_status = STATUS_NONE_DUE;
					emit_key    = '0;
					emit_time   = '0;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			num_q   <= '0;
			found_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			num_q   <= num_d;
			found_q <= found_d;
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			action_q   <= action;
			key_q      <= timer_key;
			now_q      <= current_time;
			deadline_q <= sat_deadline;
		end
		if (emit) begin
			status_q <= emit_status;
			rkey_q   <= emit_key;
			rtime_q  <= emit_time;
			last_q   <= emit_last;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign status       = status_q;
	assign result_key   = rkey_q;
	assign result_time  = rtime_q;
	assign last_result  = last_q;

endmodule

// ----- rtl/stq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks on the sorted timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_core_macros.svh"

module stq_checker
	import stq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic [ACTION_W-1:0] action,
	input logic                result_valid,
	input logic [STATUS_W-1:0] status,
	input logic                last_result
);

	// An unused action code is dropped without a beat and without work.
	`STQ_ASSERT_NEXT(a_unused_dropped, start && !busy && (action == ACT_UNUSED), !busy && !result_valid, "unused action produced activity")

	// Any other command keeps the block busy in the following cycle.
	`STQ_ASSERT_NEXT(a_cmd_busy, start && !busy && (action != ACT_UNUSED), busy && !result_valid, "command not taken up")

	// Only expired beats may be followed by more beats of the same item.
	`STQ_ASSERT_SAME(a_single_last, result_valid && (status != STATUS_EXPIRED), last_result, "single-beat result not marked last")

	// The final beat of an item coincides with the block becoming free.
	`STQ_ASSERT_SAME(a_last_free, result_valid && last_result, !busy, "busy after final beat")

	// A beat that is not final leaves the block working on the same tick.
	`STQ_ASSERT_SAME(a_more_busy, result_valid && !last_result, busy, "idle before final beat")

endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (.*);

// ----- test/tb_sorted_timer_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue_core
// Self-checking bench for the sorted timer queue. A scoreboard keeps its own
// deadline-ordered copy of the queue and predicts every result beat. Directed
// corner cases come first, then about four hundred random commands.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue_core;
	import stq_pkg::*;

	localparam int IDLE_LIMIT   = 200;  // cycles with no beat in either direction
	localparam int DRAIN_CYCLES = 24;   // settle time after the last expected beat
	localparam int RANDOM_ITEMS = 380;
	localparam int CALM_TAIL    = 60;   // final commands sent without pauses
	localparam int SEGMENT_LEN  = 40;
	localparam int KEY_POOL     = 24;
	localparam int MAX_PRINTED  = 20;

	// One result beat as the block should show it.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    key;
		logic [TIME_W-1:0]   rtime;
		logic                last;
	} timer_result_t;

	// The scoreboard holds its own copy of the queue, sorted by deadline with
	// ties kept in arrival order, and the beats that are still to come.
	class timer_queue_scoreboard;
		entry_t        timers[$];
		timer_result_t pending_results[$];
		int            mismatches;
		int            results_checked;
		int            commands[4];
		int            full_hits;
		int            reschedules;
		int            expired_total;
		int            widest_tick;

		task report_mismatch(input string what);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("%0t ns mismatch: %s", $realtime, what);
		endtask

		function int find_timer(input logic [KEY_W-1:0] key);
			for (int i = 0; i < timers.size(); i++)
				if (timers[i].key == key)
					return i;
			return -1;
		endfunction

		// A new or moved timer goes behind every timer due no later than it.
		function void insert_timer(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] deadline);
			int     pos;
			entry_t e;
			pos = 0;
			while (pos < timers.size() && timers[pos].deadline <= deadline)
				pos++;
			e.key = key;
			e.deadline = deadline;
			timers.insert(pos, e);
		endfunction

		function void expect_beat(input logic [STATUS_W-1:0] status, input logic [KEY_W-1:0] key,
				input logic [TIME_W-1:0] rtime, input logic last);
			timer_result_t r;
			r.status = status;
			r.key = key;
			r.rtime = rtime;
			r.last = last;
			pending_results.push_back(r);
		endfunction

		task note_command(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
				input logic [DELAY_W-1:0] delay, input logic [TIME_W-1:0] now);
			logic [TIME_W:0]   sum;
			logic [TIME_W-1:0] deadline;
			logic [TIME_W-1:0] left;
			int                pos;
			int                due;
			commands[act]++;
			case (act)
				ACT_REQUEST: begin
					sum = {1'b0, now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
					deadline = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
					pos = find_timer(key);
					if (pos >= 0) begin
						timers.delete(pos);
						insert_timer(key, deadline);
						expect_beat(STATUS_RESCHEDULED, key, deadline, 1'b1);
						reschedules++;
					end else if (timers.size() >= CAPACITY) begin
						expect_beat(STATUS_FULL, key, '0, 1'b1);
						full_hits++;
					end else begin
						insert_timer(key, deadline);
						expect_beat(STATUS_SCHEDULED, key, deadline, 1'b1);
					end
				end
				ACT_CANCEL: begin
					pos = find_timer(key);
					if (pos >= 0) begin
						left = (timers[pos].deadline > now) ? timers[pos].deadline - now : '0;
						timers.delete(pos);
						expect_beat(STATUS_CANCELLED, key, left, 1'b1);
					end else begin
						expect_beat(STATUS_NOT_FOUND, key, '0, 1'b1);
					end
				end
				ACT_TICK: begin
					due = 0;
					while (due < MAX_RESULTS && due < timers.size() && timers[due].deadline <= now)
						due++;
					if (due == 0)
						expect_beat(STATUS_NONE_DUE, '0, '0, 1'b1);
					for (int i = 0; i < due; i++) begin
						expect_beat(STATUS_EXPIRED, timers[0].key, timers[0].deadline, i == due - 1);
						void'(timers.pop_front());
					end
					expired_total += due;
					if (due > widest_tick)
						widest_tick = due;
				end
				default: begin
				end
			endcase
		endtask

		task check_result(input logic [STATUS_W-1:0] status, input logic [KEY_W-1:0] key,
				input logic [TIME_W-1:0] rtime, input logic last);
			timer_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("beat with nothing expected: status %0d key %h",
					status, key));
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d (key %h)",
					status, want.status, want.key));
			if (key !== want.key)
				report_mismatch($sformatf("result_key %h, expected %h", key, want.key));
			if (rtime !== want.rtime)
				report_mismatch($sformatf("result_time %h, expected %h (key %h)",
					rtime, want.rtime, want.key));
			if (last !== want.last)
				report_mismatch($sformatf("last_result %b, expected %b (key %h)",
					last, want.last, want.key));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [ACTION_W-1:0] action = ACT_TICK;
	logic [KEY_W-1:0]    timer_key = '0;
	logic [DELAY_W-1:0]  delay_seconds = '0;
	logic [TIME_W-1:0]   current_time = '0;
	logic                result_valid;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    result_key;
	logic [TIME_W-1:0]   result_time;
	logic                last_result;

	timer_queue_scoreboard queue_model;
	logic [KEY_W-1:0]      key_pool[KEY_POOL];
	logic [TIME_W-1:0]     sim_now;
	int                    pause_pct;
	int                    delay_span;
	int                    quiet_cycles = 0;

	sorted_timer_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.timer_key    (timer_key),
		.delay_seconds(delay_seconds),
		.current_time (current_time),
		.result_valid (result_valid),
		.status       (status),
		.result_key   (result_key),
		.result_time  (result_time),
		.last_result  (last_result)
	);

	always #5 clk = ~clk;

	// Result beats cannot be held off, so every strobe is checked at the edge
	// that ends it. Values are read before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			queue_model.check_result(status, result_key, result_time, last_result);
	end

	// The watchdog restarts whenever a beat moves in either direction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("tb_sorted_timer_queue_core: errors");
				$finish;
			end
		end
	end

	// Offers one command and holds it until the block takes it. The caller
	// is always just past a rising edge, so start is never dropped and raised
	// in the same step between back-to-back commands.
	task automatic issue_command(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
			input logic [DELAY_W-1:0] delay, input logic [TIME_W-1:0] now);
		start <= 1'b1;
		action <= act;
		timer_key <= key;
		delay_seconds <= delay;
		current_time <= now;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		queue_model.note_command(act, key, delay, now);
	endtask

	// A sender pause: start is low and the payload carries rubbish, which the
	// block must ignore.
	task automatic idle_cycles(input int n);
		start <= 1'b0;
		action <= ACTION_W'($urandom);
		timer_key <= KEY_W'($urandom);
		delay_seconds <= DELAY_W'($urandom);
		current_time <= $urandom;
		repeat (n)
			@(posedge clk);
	endtask

	task automatic maybe_pause();
		if (pause_pct > 0 && $urandom_range(0, 99) < pause_pct)
			idle_cycles($urandom_range(1, 6));
	endtask

	// Mostly keys from a small pool, so that reschedules, cancels of live
	// timers and a full queue all come up; now and then any key at all.
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return KEY_W'($urandom);
		return key_pool[$urandom_range(0, KEY_POOL - 1)];
	endfunction

	function automatic logic [DELAY_W-1:0] pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return DELAY_W'($urandom);
		return DELAY_W'($urandom_range(0, delay_span));
	endfunction

	// Time mostly creeps forward so that ticks find timers due; occasional
	// jumps reach every bit of the time field and the top of its range.
	task automatic advance_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			sim_now = $urandom;
		else if (r < 5)
			sim_now = 32'hFFFF_FFFF - $urandom_range(0, 100);
		else
			sim_now = sim_now + $urandom_range(0, 6);
	endtask

	initial begin
		int                  sent;
		int                  r;
		logic [ACTION_W-1:0] act;

		queue_model = new();
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = KEY_W'($urandom);
		pause_pct = 0;
		delay_span = 24;

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corner cases, back to back.
		issue_command(ACT_TICK, '0, '0, '0);                        // nothing due
		issue_command(ACT_CANCEL, 16'hA5A5, '0, 32'h1234_5678);     // unknown key
		issue_command(ACT_REQUEST, 16'h0000, 16'h0000, '0);         // deadline of zero
		issue_command(ACT_REQUEST, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0); // saturating deadline
		issue_command(ACT_REQUEST, 16'h0000, 16'd7, 32'd3);         // moves a queued timer
		issue_command(ACT_CANCEL, 16'hFFFF, '0, '0);                // largest time left
		issue_command(ACT_REQUEST, 16'h0001, 16'd2, 32'd4);
		issue_command(ACT_CANCEL, 16'h0001, '0, 32'd50);            // deadline already past
		issue_command(ACT_TICK, '0, '0, 32'hFFFF_FFFF);
		issue_command(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF); // dropped

		// Fill the queue with clustered deadlines so that equal deadlines keep
		// their arrival order, then try a new key against the full queue, move
		// a queued timer while full and expire the lot with one tick.
		for (int i = 0; i < CAPACITY; i++)
			issue_command(ACT_REQUEST, KEY_W'(16'h0100 + i), DELAY_W'(i % 4), 32'd1000);
		issue_command(ACT_REQUEST, 16'h0200, 16'd1, 32'd1000);
		issue_command(ACT_REQUEST, 16'h0105, 16'd0, 32'd0);
		issue_command(ACT_TICK, '0, '0, 32'hFFFF_FFFF);

		// Random part. Each segment picks its own pause rate and delay spread;
		// the final stretch runs with no pauses at all.
		sim_now = $urandom_range(0, 1000);
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % SEGMENT_LEN == 0) begin
				case ($urandom_range(0, 2))
					0: pause_pct = 0;
					1: pause_pct = 30;
					default: pause_pct = 60;
				endcase
				delay_span = ($urandom_range(0, 1) == 0) ? 8 : 200;
			end
			if (sent >= RANDOM_ITEMS - CALM_TAIL)
				pause_pct = 0;
			advance_time();
			r = $urandom_range(0, 99);
			if (r < 45)
				act = ACT_REQUEST;
			else if (r < 65)
				act = ACT_CANCEL;
			else if (r < 96)
				act = ACT_TICK;
			else
				act = ACT_UNUSED;
			issue_command(act, pick_key(), pick_delay(), sim_now);
			if (act != ACT_UNUSED)
				sent++;
			maybe_pause();
		end

		start <= 1'b0;
		while (queue_model.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("covered %0d requests, %0d cancels, %0d ticks, %0d dropped commands",
			queue_model.commands[ACT_REQUEST], queue_model.commands[ACT_CANCEL],
			queue_model.commands[ACT_TICK], queue_model.commands[ACT_UNUSED]);
		$display("%0d beats checked: %0d expiries (up to %0d per tick), %0d moves, %0d full",
			queue_model.results_checked, queue_model.expired_total, queue_model.widest_tick,
			queue_model.reschedules, queue_model.full_hits);
		if (queue_model.mismatches == 0)
			$display("tb_sorted_timer_queue_core: clean");
		else
			$display("tb_sorted_timer_queue_core: errors");
		$finish;
	end

endmodule
